FILE: rtl/mpsp_pkg.sv
// Package for the MAC PDU subheader parser: types, constants and helpers.
// No dependencies; every module of the block imports it.
package mpsp_pkg;

    // Saturating byte counters in the summary word
    localparam int COUNT_BITS     = 12;
    localparam int LCID_BITS      = 5;
    localparam int LEN_BITS       = 7;
    localparam int LEVEL_BITS     = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 5;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    // Room held back for the staged byte and a newly taken byte
    localparam int QUEUE_SLACK = 4;

    // Fixed header and length fields
    localparam int HDR_EXT_BIT   = 5;
    localparam int LONG_BSR_LEN  = 3;

    typedef enum logic [2:0] {
        PH_SUB   = 3'd0,
        PH_LEN   = 3'd1,
        PH_PAY   = 3'd2,
        PH_LONG  = 3'd3,
        PH_SHORT = 3'd4,
        PH_TRUNC = 3'd5,
        PH_OTHER = 3'd6,
        PH_PAD   = 3'd7
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_DATA  = 3'd0,
        CFG_SHORT_BSR = 3'd1,
        CFG_TRUNC_BSR = 3'd2,
        CFG_LONG_BSR  = 3'd3,
        CFG_PADDING   = 3'd4
    } cfg_index_t;

    // Register defaults
    localparam logic [LCID_BITS-1:0] MAX_DATA_RST  = 5'd10;
    localparam logic [LCID_BITS-1:0] SHORT_BSR_RST = 5'd29;
    localparam logic [LCID_BITS-1:0] TRUNC_BSR_RST = 5'd28;
    localparam logic [LCID_BITS-1:0] LONG_BSR_RST  = 5'd30;
    localparam logic [LCID_BITS-1:0] PADDING_RST   = 5'd31;

    // Record kinds
    localparam logic [1:0] REC_DATA    = 2'd0;
    localparam logic [1:0] REC_BSR     = 2'd1;
    localparam logic [1:0] REC_SUMMARY = 2'd2;

    // BSR kinds
    localparam logic [1:0] BSR_SHORT = 2'd0;
    localparam logic [1:0] BSR_TRUNC = 2'd1;
    localparam logic [1:0] BSR_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]            record_kind;
        logic [LCID_BITS-1:0]  channel_id;
        logic [LEN_BITS-1:0]   sdu_length;
        logic [1:0]            bsr_kind;
        logic [1:0]            group_id;
        logic [LEVEL_BITS-1:0] level_zero;
        logic [LEVEL_BITS-1:0] level_one;
        logic [LEVEL_BITS-1:0] level_two;
        logic [LEVEL_BITS-1:0] level_three;
        logic [COUNT_BITS-1:0] bytes_consumed;
        logic [COUNT_BITS-1:0] pad_count;
        logic                  run_last;
    } result_t;

    // Up to two records produced by one byte, oldest in first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    // Counter add that sticks at all ones
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [LEN_BITS-1:0]   b
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + (COUNT_BITS + 1)'(b);
        if (sum[COUNT_BITS])
            return {COUNT_BITS{1'b1}};
        return sum[COUNT_BITS-1:0];
    endfunction

endpackage

FILE: rtl/mpsp_pdu_if.sv
// Byte channel into the MAC PDU subheader parser.
// Depends on nothing.
interface mpsp_pdu_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       pdu_end;

    modport source (output valid, output data_byte, output pdu_end, input ready);
    modport sink   (input valid, input data_byte, input pdu_end, output ready);
endinterface

FILE: rtl/mpsp_rec_if.sv
// Record channel out of the MAC PDU subheader parser.
// Depends on nothing; field widths follow the record layout in mpsp_pkg.
interface mpsp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [4:0]  channel_id;
    logic [6:0]  sdu_length;
    logic [1:0]  bsr_kind;
    logic [1:0]  group_id;
    logic [5:0]  level_zero;
    logic [5:0]  level_one;
    logic [5:0]  level_two;
    logic [5:0]  level_three;
    logic [11:0] bytes_consumed;
    logic [11:0] pad_count;
    logic        run_last;

    modport source (
        output valid, output record_kind, output channel_id, output sdu_length,
        output bsr_kind, output group_id, output level_zero, output level_one,
        output level_two, output level_three, output bytes_consumed,
        output pad_count, output run_last, input ready
    );
    modport sink (
        input valid, input record_kind, input channel_id, input sdu_length,
        input bsr_kind, input group_id, input level_zero, input level_one,
        input level_two, input level_three, input bytes_consumed,
        input pad_count, input run_last, output ready
    );
endinterface

FILE: rtl/mac_pdu_subheader_parser.sv
// Uplink MAC PDU subheader parser, top level.
// Throughput: one PDU byte per cycle, sustained, whatever the record pattern,
// while the result queue has room; a stalled receiver drops pdu.ready.
// Byte stage, then parse step into the result queue, whose head drives rec.
// rst_n (async, active low) clears parse state, queue and the code
// registers to their defaults; no clearing pass, bytes are taken at once.
module mac_pdu_subheader_parser
    import mpsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    mpsp_pdu_if.sink                  pdu,
    mpsp_rec_if.source                rec,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    push_t                push;
    logic                 room;
    logic [QCNT_BITS-1:0] q_count;

    mpsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .pdu       (pdu),
        .room      (room),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    mpsp_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .rec   (rec),
        .room  (room),
        .count (q_count)
    );

    // Records only come from a word taken the cycle before
    a_push_from_word: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> $past(pdu.valid && pdu.ready))
        else $error("record pushed without an accepted word");

    // The last byte of a PDU always yields a summary
    a_end_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
        pdu.valid && pdu.ready && pdu.pdu_end |=> push.cnt != 2'd0)
        else $error("no summary for end of PDU");

    // Queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Output valid tracks queue occupancy
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid == (q_count != '0))
        else $error("rec.valid out of step with queue fill");

endmodule

FILE: rtl/mpsp_parser.sv
// Byte stage, parse state and configuration registers of the subheader parser.
// Depends on mpsp_pkg and mpsp_pdu_if.
module mpsp_parser
    import mpsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    mpsp_pdu_if.sink                  pdu,
    input  logic                      room,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output push_t                     push
);

    // Configuration
    logic [LCID_BITS-1:0] max_data_reg, short_bsr_reg, trunc_bsr_reg;
    logic [LCID_BITS-1:0] long_bsr_reg, padding_reg;

    // Staged input word
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_end_reg;

    // Parse state
    phase_t                phase_reg, phase_next;
    logic                  more_reg, more_next;
    logic [LCID_BITS-1:0]  chan_reg, chan_next;
    logic [LEN_BITS-1:0]   left_reg, left_next;
    logic [LEN_BITS-1:0]   held_len_reg, held_len_next;
    logic [1:0]            seen_reg, seen_next;
    logic [15:0]           bsr_reg, bsr_next;
    logic [COUNT_BITS-1:0] consumed_reg, consumed_next;
    logic [COUNT_BITS-1:0] padcnt_reg, padcnt_next;

    logic                  el_valid;
    result_t               el_rec, sum_rec;
    logic [LCID_BITS-1:0]  lcid;
    logic [23:0]           long_bits;

    assign pdu.ready = room;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_data_reg  <= MAX_DATA_RST;
            short_bsr_reg <= SHORT_BSR_RST;
            trunc_bsr_reg <= TRUNC_BSR_RST;
            long_bsr_reg  <= LONG_BSR_RST;
            padding_reg   <= PADDING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_DATA:  max_data_reg  <= cfg_data;
                CFG_SHORT_BSR: short_bsr_reg <= cfg_data;
                CFG_TRUNC_BSR: trunc_bsr_reg <= cfg_data;
                CFG_LONG_BSR:  long_bsr_reg  <= cfg_data;
                CFG_PADDING:   padding_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: one word per cycle while the result queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= pdu.valid && pdu.ready;
    end

    always_ff @(posedge clk)
    begin
        if (pdu.valid && pdu.ready)
        begin
            stg_byte_reg <= pdu.data_byte;
            stg_end_reg  <= pdu.pdu_end;
        end
    end

    assign lcid      = stg_byte_reg[LCID_BITS-1:0];
    assign long_bits = {bsr_reg, stg_byte_reg};

    // Per-byte parse step
    always_comb
    begin
        phase_next    = phase_reg;
        more_next     = more_reg;
        chan_next     = chan_reg;
        left_next     = left_reg;
        held_len_next = held_len_reg;
        seen_next     = seen_reg;
        bsr_next      = bsr_reg;
        consumed_next = consumed_reg;
        padcnt_next   = padcnt_reg;
        el_valid      = 1'b0;
        el_rec        = '0;
        sum_rec       = '0;

        unique case (phase_reg)
            PH_SUB:
            begin
                if (more_reg)
                begin
                    more_next     = stg_byte_reg[HDR_EXT_BIT];
                    chan_next     = lcid;
                    consumed_next = sat_add(consumed_reg, LEN_BITS'(1));
                    priority if (lcid == padding_reg)
                        phase_next = PH_PAD;
                    else if (lcid <= max_data_reg)
                        phase_next = PH_LEN;
                    else if (lcid == long_bsr_reg)
                    begin
                        phase_next = PH_LONG;
                        seen_next  = 2'd0;
                    end
                    else if (lcid == trunc_bsr_reg)
                        phase_next = PH_TRUNC;
                    else if (lcid == short_bsr_reg)
                        phase_next = PH_SHORT;
                    else
                        phase_next = PH_OTHER;
                end
            end
            PH_LEN:
            begin
                held_len_next = stg_byte_reg[LEN_BITS-1:0];
                consumed_next = sat_add(consumed_reg, LEN_BITS'(1));
                if (stg_byte_reg[LEN_BITS-1:0] == '0)
                begin
                    el_valid           = 1'b1;
                    el_rec.record_kind = REC_DATA;
                    el_rec.channel_id  = chan_reg;
                    phase_next         = PH_SUB;
                end
                else
                begin
                    left_next  = stg_byte_reg[LEN_BITS-1:0];
                    phase_next = PH_PAY;
                end
            end
            PH_PAY:
            begin
                left_next = left_reg - LEN_BITS'(1);
                if (left_reg == LEN_BITS'(1))
                begin
                    consumed_next      = sat_add(consumed_reg, held_len_reg);
                    el_valid           = 1'b1;
                    el_rec.record_kind = REC_DATA;
                    el_rec.channel_id  = chan_reg;
                    el_rec.sdu_length  = held_len_reg;
                    phase_next         = PH_SUB;
                end
            end
            PH_LONG:
            begin
                if (seen_reg < 2'd2)
                begin
                    bsr_next  = {bsr_reg[7:0], stg_byte_reg};
                    seen_next = seen_reg + 2'd1;
                end
                else
                begin
                    consumed_next      = sat_add(consumed_reg, LEN_BITS'(LONG_BSR_LEN));
                    el_valid           = 1'b1;
                    el_rec.record_kind = REC_BSR;
                    el_rec.bsr_kind    = BSR_LONG;
                    el_rec.level_zero  = long_bits[23:18];
                    el_rec.level_one   = long_bits[17:12];
                    el_rec.level_two   = long_bits[11:6];
                    el_rec.level_three = long_bits[5:0];
                    seen_next          = 2'd0;
                    phase_next         = PH_SUB;
                end
            end
            PH_SHORT, PH_TRUNC:
            begin
                consumed_next      = sat_add(consumed_reg, LEN_BITS'(1));
                el_valid           = 1'b1;
                el_rec.record_kind = REC_BSR;
                el_rec.bsr_kind    = (phase_reg == PH_TRUNC) ? BSR_TRUNC : BSR_SHORT;
                el_rec.group_id    = stg_byte_reg[7:6];
                el_rec.level_zero  = stg_byte_reg[5:0];
                phase_next         = PH_SUB;
            end
            PH_OTHER:
            begin
                consumed_next = sat_add(consumed_reg, LEN_BITS'(1));
                phase_next    = PH_SUB;
            end
            PH_PAD:
            begin
                padcnt_next = sat_add(padcnt_reg, LEN_BITS'(1));
            end
            default: ;
        endcase

        el_rec.run_last = !stg_end_reg;

        // Last byte: summary and re-arm for the next PDU
        sum_rec.record_kind    = REC_SUMMARY;
        sum_rec.bytes_consumed = consumed_next;
        sum_rec.pad_count      = padcnt_next;
        sum_rec.run_last       = 1'b1;
        if (stg_end_reg)
        begin
            phase_next    = PH_SUB;
            more_next     = 1'b1;
            chan_next     = '0;
            left_next     = '0;
            held_len_next = '0;
            seen_next     = '0;
            bsr_next      = '0;
            consumed_next = '0;
            padcnt_next   = '0;
        end
    end

    // Records handed to the queue
    always_comb
    begin
        push.cnt    = 2'd0;
        push.first  = el_rec;
        push.second = sum_rec;
        if (stg_valid_reg)
        begin
            if (el_valid && stg_end_reg)
                push.cnt = 2'd2;
            else if (el_valid)
                push.cnt = 2'd1;
            else if (stg_end_reg)
            begin
                push.cnt   = 2'd1;
                push.first = sum_rec;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SUB;
            more_reg     <= 1'b1;
            chan_reg     <= '0;
            left_reg     <= '0;
            held_len_reg <= '0;
            seen_reg     <= '0;
            bsr_reg      <= '0;
            consumed_reg <= '0;
            padcnt_reg   <= '0;
        end
        else if (stg_valid_reg)
        begin
            phase_reg    <= phase_next;
            more_reg     <= more_next;
            chan_reg     <= chan_next;
            left_reg     <= left_next;
            held_len_reg <= held_len_next;
            seen_reg     <= seen_next;
            bsr_reg      <= bsr_next;
            consumed_reg <= consumed_next;
            padcnt_reg   <= padcnt_next;
        end
    end

endmodule

FILE: rtl/mpsp_out_queue.sv
// Result queue of the subheader parser: takes up to two records a cycle,
// gives one a cycle while rec.ready is high. Uses mpsp_pkg and mpsp_rec_if.
module mpsp_out_queue
    import mpsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  push_t                push,
    mpsp_rec_if.source           rec,
    output logic                 room,
    output logic [QCNT_BITS-1:0] count
);

    result_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   head_reg, tail_reg;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   pop;
    result_t                head_rec;

    assign pop      = rec.valid && rec.ready;
    assign room     = count_reg <= QCNT_BITS'(QUEUE_DEPTH - QUEUE_SLACK);
    assign count    = count_reg;
    assign head_rec = entries_reg[head_reg];

    assign count_next = count_reg + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            entries_reg[tail_reg] <= push.first;
        if (push.cnt == 2'd2)
            entries_reg[tail_reg + QPTR_BITS'(1)] <= push.second;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + QPTR_BITS'(push.cnt);
            head_reg  <= head_reg + QPTR_BITS'(pop);
            count_reg <= count_next;
        end
    end

    // Head word onto the channel
    assign rec.valid          = count_reg != '0;
    assign rec.record_kind    = head_rec.record_kind;
    assign rec.channel_id     = head_rec.channel_id;
    assign rec.sdu_length     = head_rec.sdu_length;
    assign rec.bsr_kind       = head_rec.bsr_kind;
    assign rec.group_id       = head_rec.group_id;
    assign rec.level_zero     = head_rec.level_zero;
    assign rec.level_one      = head_rec.level_one;
    assign rec.level_two      = head_rec.level_two;
    assign rec.level_three    = head_rec.level_three;
    assign rec.bytes_consumed = head_rec.bytes_consumed;
    assign rec.pad_count      = head_rec.pad_count;
    assign rec.run_last       = head_rec.run_last;

endmodule

FILE: tb/sv/mpsp_checker.sv
`timescale 1ns / 1ps
// Checker for the MAC PDU subheader parser: watches the byte, record and register ports,
// predicts the records of every accepted byte word and compares them in order.
// Depends on mpsp_pkg, mpsp_pdu_if and mpsp_rec_if.
module mpsp_checker
    import mpsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    mpsp_pdu_if                       pdu,
    mpsp_rec_if                       rec,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    // Own copy of the code registers
    logic [LCID_BITS-1:0] top_data_lcid;
    logic [LCID_BITS-1:0] short_lcid;
    logic [LCID_BITS-1:0] trunc_lcid;
    logic [LCID_BITS-1:0] long_lcid;
    logic [LCID_BITS-1:0] pad_lcid;

    // Parse state of the PDU in flight
    phase_t                parse_phase;
    logic                  ext_pending;
    logic [LCID_BITS-1:0]  chan;
    logic [LEN_BITS-1:0]   bytes_left;
    logic [LEN_BITS-1:0]   sdu_len;
    logic [1:0]            long_seen;
    logic [15:0]           long_bits;
    logic [COUNT_BITS-1:0] used_count;
    logic [COUNT_BITS-1:0] padded_count;

    result_t awaited_records[$];

    // Counter add that sticks at the top value
    function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] count,
                                                   int unsigned step);
        int unsigned total;
        total = count + step;
        if (total > (2**COUNT_BITS - 1))
            return {COUNT_BITS{1'b1}};
        return COUNT_BITS'(total);
    endfunction

    function automatic void clear_frame_state();
        parse_phase  = PH_SUB;
        ext_pending  = 1'b1;
        chan         = '0;
        bytes_left   = '0;
        sdu_len      = '0;
        long_seen    = '0;
        long_bits    = '0;
        used_count   = '0;
        padded_count = '0;
    endfunction

    // Advance the parse by one byte word and queue the records it causes
    function automatic void parse_byte(logic [7:0] b, logic last);
        result_t       recs[2];
        int            n;
        logic [23:0]   bits;
        logic [LCID_BITS-1:0] lcid;
        recs[0] = '0;
        recs[1] = '0;
        n = 0;
        case (parse_phase)
            PH_SUB:
            begin
                if (ext_pending)
                begin
                    lcid        = b[LCID_BITS-1:0];
                    ext_pending = b[HDR_EXT_BIT];
                    chan        = lcid;
                    used_count  = bump(used_count, 1);
                    // padding wins over every other code
                    if (lcid == pad_lcid)
                        parse_phase = PH_PAD;
                    else if (lcid <= top_data_lcid)
                        parse_phase = PH_LEN;
                    else if (lcid == long_lcid)
                    begin
                        parse_phase = PH_LONG;
                        long_seen   = '0;
                    end
                    else if (lcid == trunc_lcid)
                        parse_phase = PH_TRUNC;
                    else if (lcid == short_lcid)
                        parse_phase = PH_SHORT;
                    else
                        parse_phase = PH_OTHER;
                end
            end
            PH_LEN:
            begin
                sdu_len    = b[LEN_BITS-1:0];
                used_count = bump(used_count, 1);
                if (sdu_len == 0)
                begin
                    // empty SDU reported on its length byte
                    recs[0].record_kind = REC_DATA;
                    recs[0].channel_id  = chan;
                    n = 1;
                    parse_phase = PH_SUB;
                end
                else
                begin
                    bytes_left  = sdu_len;
                    parse_phase = PH_PAY;
                end
            end
            PH_PAY:
            begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0)
                begin
                    used_count = bump(used_count, sdu_len);
                    recs[0].record_kind = REC_DATA;
                    recs[0].channel_id  = chan;
                    recs[0].sdu_length  = sdu_len;
                    n = 1;
                    parse_phase = PH_SUB;
                end
            end
            PH_LONG:
            begin
                if (long_seen < 2)
                begin
                    long_bits = {long_bits[7:0], b};
                    long_seen = long_seen + 1'b1;
                end
                else
                begin
                    bits       = {long_bits, b};
                    used_count = bump(used_count, LONG_BSR_LEN);
                    recs[0].record_kind = REC_BSR;
                    recs[0].bsr_kind    = BSR_LONG;
                    recs[0].level_zero  = bits[23:18];
                    recs[0].level_one   = bits[17:12];
                    recs[0].level_two   = bits[11:6];
                    recs[0].level_three = bits[5:0];
                    n = 1;
                    long_seen   = '0;
                    parse_phase = PH_SUB;
                end
            end
            PH_SHORT, PH_TRUNC:
            begin
                used_count = bump(used_count, 1);
                recs[0].record_kind = REC_BSR;
                recs[0].bsr_kind    = (parse_phase == PH_TRUNC) ? BSR_TRUNC : BSR_SHORT;
                recs[0].group_id    = b[7:6];
                recs[0].level_zero  = b[5:0];
                n = 1;
                parse_phase = PH_SUB;
            end
            PH_OTHER:
            begin
                used_count  = bump(used_count, 1);
                parse_phase = PH_SUB;
            end
            default:
            begin
                padded_count = bump(padded_count, 1);
            end
        endcase

        // last byte of the PDU: summary, then re-arm
        if (last)
        begin
            recs[n].record_kind    = REC_SUMMARY;
            recs[n].bytes_consumed = used_count;
            recs[n].pad_count      = padded_count;
            n++;
            clear_frame_state();
        end
        if (n > 0)
            recs[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_records.insert(awaited_records.size(), recs[i]);
    endfunction

    function automatic string record_text(result_t r);
        return $sformatf({"kind=%0d ch=%0d len=%0d bsr=%0d grp=%0d lv=%0d/%0d/%0d/%0d",
                          " cons=%0d pad=%0d last=%0d"},
                         r.record_kind, r.channel_id, r.sdu_length, r.bsr_kind, r.group_id,
                         r.level_zero, r.level_one, r.level_two, r.level_three,
                         r.bytes_consumed, r.pad_count, r.run_last);
    endfunction

    function automatic string field_diffs(result_t want, result_t got);
        string s;
        s = "";
        if (got.record_kind !== want.record_kind)       s = {s, " record_kind"};
        if (got.channel_id !== want.channel_id)         s = {s, " channel_id"};
        if (got.sdu_length !== want.sdu_length)         s = {s, " sdu_length"};
        if (got.bsr_kind !== want.bsr_kind)             s = {s, " bsr_kind"};
        if (got.group_id !== want.group_id)             s = {s, " group_id"};
        if (got.level_zero !== want.level_zero)         s = {s, " level_zero"};
        if (got.level_one !== want.level_one)           s = {s, " level_one"};
        if (got.level_two !== want.level_two)           s = {s, " level_two"};
        if (got.level_three !== want.level_three)       s = {s, " level_three"};
        if (got.bytes_consumed !== want.bytes_consumed) s = {s, " bytes_consumed"};
        if (got.pad_count !== want.pad_count)           s = {s, " pad_count"};
        if (got.run_last !== want.run_last)             s = {s, " run_last"};
        return s;
    endfunction

    // Compare accepted records, then predict from the accepted byte word
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        string   diffs;
        if (!rst_n)
        begin
            top_data_lcid = MAX_DATA_RST;
            short_lcid    = SHORT_BSR_RST;
            trunc_lcid    = TRUNC_BSR_RST;
            long_lcid     = LONG_BSR_RST;
            pad_lcid      = PADDING_RST;
            clear_frame_state();
            awaited_records.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rec.valid && rec.ready)
            begin
                got.record_kind    = rec.record_kind;
                got.channel_id     = rec.channel_id;
                got.sdu_length     = rec.sdu_length;
                got.bsr_kind       = rec.bsr_kind;
                got.group_id       = rec.group_id;
                got.level_zero     = rec.level_zero;
                got.level_one      = rec.level_one;
                got.level_two      = rec.level_two;
                got.level_three    = rec.level_three;
                got.bytes_consumed = rec.bytes_consumed;
                got.pad_count      = rec.pad_count;
                got.run_last       = rec.run_last;
                if (awaited_records.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected record %s", $realtime, record_text(got));
                    mismatches++;
                end
                else
                begin
                    want  = awaited_records.pop_front();
                    diffs = field_diffs(want, got);
                    if (diffs != "")
                    begin
                        if (mismatches < 10)
                            $display("%0t: record mismatch on%s\n  expected %s\n  actual   %s",
                                     $realtime, diffs, record_text(want), record_text(got));
                        mismatches++;
                    end
                end
            end

            if (pdu.valid && pdu.ready)
                parse_byte(pdu.data_byte, pdu.pdu_end);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_DATA:  top_data_lcid = cfg_data;
                    CFG_SHORT_BSR: short_lcid    = cfg_data;
                    CFG_TRUNC_BSR: trunc_lcid    = cfg_data;
                    CFG_LONG_BSR:  long_lcid     = cfg_data;
                    CFG_PADDING:   pad_lcid      = cfg_data;
                    default: ;
                endcase
            end

            outstanding <= awaited_records.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the MAC PDU subheader parser: clock, reset, PDU stimulus, register
// settings and receiver stalls; verdict from mpsp_checker. Depends on mpsp_pkg and both
// channel interfaces.
module tb;
    import mpsp_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int SETTINGS_RUN = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int hold_asks  = 0;
    int burst_left = 0;

    // Codes the generator aims at, kept in step with the registers
    logic [LCID_BITS-1:0] gen_max_data = MAX_DATA_RST;
    logic [LCID_BITS-1:0] gen_short    = SHORT_BSR_RST;
    logic [LCID_BITS-1:0] gen_trunc    = TRUNC_BSR_RST;
    logic [LCID_BITS-1:0] gen_long     = LONG_BSR_RST;
    logic [LCID_BITS-1:0] gen_pad      = PADDING_RST;

    logic [7:0] frame[$];

    mpsp_pdu_if pdu_bus();
    mpsp_rec_if rec_bus();

    mac_pdu_subheader_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pdu       (pdu_bus),
        .rec       (rec_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mpsp_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pdu         (pdu_bus),
        .rec         (rec_bus),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Add one byte at the end of the frame
    function automatic void append_byte(logic [7:0] value);
        frame.insert(frame.size(), value);
    endfunction

    // Subheader byte with random reserved bits
    function automatic logic [7:0] sub_byte(logic [LCID_BITS-1:0] lcid, logic ext);
        return {2'($urandom_range(0, 3)), ext, lcid};
    endfunction

    function automatic void add_data(logic [LCID_BITS-1:0] lcid, int len, logic ext);
        append_byte(sub_byte(lcid, ext));
        append_byte({1'($urandom_range(0, 1)), 7'(len)});
        repeat (len) append_byte(8'($urandom));
    endfunction

    function automatic void add_ctrl(logic [LCID_BITS-1:0] lcid, int body, logic ext);
        append_byte(sub_byte(lcid, ext));
        repeat (body) append_byte(8'($urandom));
    endfunction

    // Mostly well-formed PDUs; some noise, some cut short, some with ignored tail
    function automatic int build_random_frame();
        int   elems;
        int   pick;
        int   len;
        int   ignored;
        int   keep;
        logic ext;
        logic padded;
        frame.delete();
        ignored = 0;
        padded  = 1'b0;
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
            return frame.size();
        end
        elems = $urandom_range(1, 6);
        for (int e = 0; e < elems; e++)
        begin
            ext = (e != elems - 1);
            if (!ext && $urandom_range(0, 9) == 0)
                ext = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 8);
                add_data(5'($urandom_range(0, gen_max_data)), len, ext);
            end
            else if (pick < 55)
                add_ctrl(gen_long, LONG_BSR_LEN, ext);
            else if (pick < 67)
                add_ctrl(gen_short, 1, ext);
            else if (pick < 79)
                add_ctrl(gen_trunc, 1, ext);
            else if (pick < 90)
                add_ctrl(5'($urandom), 1, ext);
            else
            begin
                add_ctrl(gen_pad, $urandom_range(0, 5), 1'($urandom_range(0, 1)));
                padded = 1'b1;
                break;
            end
        end
        if (!padded && $urandom_range(0, 3) == 0)
        begin
            ignored = $urandom_range(1, 3);
            repeat (ignored) append_byte(8'($urandom));
        end
        // element cut off by the end of the PDU
        if ($urandom_range(0, 99) < 12)
        begin
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep)
                void'(frame.pop_back());
            ignored = 0;
        end
        return frame.size() - ignored;
    endfunction

    // Offer one byte word, in bursts with random gaps
    task automatic push_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pdu_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        pdu_bus.valid     <= 1'b1;
        pdu_bus.data_byte <= value;
        pdu_bus.pdu_end   <= last;
        @(posedge clk);
        while (!pdu_bus.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            push_byte(frame[i], i == frame.size() - 1);
    endtask

    // Stop offering and wait until every record is in and the pipe is quiet
    task automatic settle();
        pdu_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic program_codes(input logic [LCID_BITS-1:0] max_data,
                                 input logic [LCID_BITS-1:0] short_code,
                                 input logic [LCID_BITS-1:0] trunc_code,
                                 input logic [LCID_BITS-1:0] long_code,
                                 input logic [LCID_BITS-1:0] pad_code);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_DATA;
        cfg_data  <= max_data;
        @(posedge clk);
        cfg_index <= CFG_SHORT_BSR;
        cfg_data  <= short_code;
        @(posedge clk);
        cfg_index <= CFG_TRUNC_BSR;
        cfg_data  <= trunc_code;
        @(posedge clk);
        cfg_index <= CFG_LONG_BSR;
        cfg_data  <= long_code;
        @(posedge clk);
        cfg_index <= CFG_PADDING;
        cfg_data  <= pad_code;
        @(posedge clk);
        cfg_we <= 1'b0;
        gen_max_data = max_data;
        gen_short    = short_code;
        gen_trunc    = trunc_code;
        gen_long     = long_code;
        gen_pad      = pad_code;
    endtask

    // Receiver: windows of varying ready odds, plus long hold-offs on request
    initial
    begin
        int window;
        int odds;
        int served;
        window = 0;
        odds   = 100;
        served = 0;
        rec_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks != served)
            begin
                served++;
                rec_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (window == 0)
            begin
                window = $urandom_range(8, 64);
                case ($urandom_range(0, 4))
                    0, 1:    odds = 100;
                    2:       odds = 80;
                    3:       odds = 50;
                    default: odds = 25;
                endcase
            end
            window--;
            rec_bus.ready <= ($urandom_range(1, 100) <= odds);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int sent;
        pdu_bus.valid     = 1'b0;
        pdu_bus.data_byte = '0;
        pdu_bus.pdu_end   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MAX_DATA;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every element kind but padding, empty SDU, extremes of the body bytes, ignored tail
        frame.delete();
        add_data(5'd0, 0, 1'b1);
        append_byte(sub_byte(gen_short, 1'b1));
        append_byte(8'hFF);
        append_byte(sub_byte(gen_trunc, 1'b1));
        append_byte(8'h00);
        append_byte(sub_byte(gen_long, 1'b1));
        append_byte(8'hFF);
        append_byte(8'h00);
        append_byte(8'hAB);
        append_byte(sub_byte(5'd20, 1'b1));
        append_byte(8'h5A);
        add_data(gen_max_data, 2, 1'b0);
        append_byte(8'hFF);
        send_frame();

        // Padding ends parsing, rest counted as padding
        frame.delete();
        append_byte(sub_byte(gen_pad, 1'b1));
        append_byte(8'h00);
        append_byte(8'hFF);
        send_frame();

        // SDU cut off by the end of the PDU
        frame.delete();
        add_data(5'd3, 5, 1'b1);
        while (frame.size() > 4)
            void'(frame.pop_back());
        send_frame();

        // One-byte PDU
        frame.delete();
        append_byte(8'hFF);
        send_frame();

        for (int p = 0; p < SETTINGS_RUN; p++)
        begin
            settle();
            case (p)
                0: program_codes(MAX_DATA_RST, SHORT_BSR_RST, TRUNC_BSR_RST, LONG_BSR_RST,
                                 PADDING_RST);
                1: program_codes(5'd0, 5'd31, 5'd30, 5'd29, 5'd1);
                2: program_codes(5'd31, 5'd0, 5'd0, 5'd0, 5'd31);
                3: program_codes(5'd6, 5'd7, 5'd7, 5'd7, 5'd0);
                4: program_codes(5'd12, 5'd20, 5'd21, 5'd12, 5'd13);
                default: program_codes(5'($urandom), 5'($urandom), 5'($urandom),
                                       5'($urandom), 5'($urandom));
            endcase

            if (p == 0)
            begin
                // both counters driven into saturation
                frame.delete();
                add_ctrl(gen_pad, 4200, 1'b1);
                send_frame();
                frame.delete();
                repeat (33) add_data(5'($urandom_range(0, gen_max_data)), 127, 1'b1);
                add_ctrl(gen_short, 1, 1'b0);
                send_frame();
            end

            // long receiver hold-off while bytes keep coming
            if (p == 2)
                hold_asks++;

            sent = 0;
            while (sent < RANDOM_ITEMS / SETTINGS_RUN)
            begin
                sent += build_random_frame();
                send_frame();
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: mac_pdu_subheader_parser.f
rtl/mpsp_pkg.sv
rtl/mpsp_pdu_if.sv
rtl/mpsp_rec_if.sv
rtl/mpsp_parser.sv
rtl/mpsp_out_queue.sv
rtl/mac_pdu_subheader_parser.sv
tb/sv/mpsp_checker.sv
tb/sv/tb.sv
